// ===== rtl/bba_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_pkg
// Shared widths, node state codes, datapath commands and status flags for the
// buddy block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int MAX_ORDER = 10;
    localparam int ORD_W     = 4;
    localparam int PAGE_W    = MAX_ORDER;
    localparam int REQ_W     = MAX_ORDER + 1;
    localparam int NODE_W    = MAX_ORDER + 1;
    localparam int NODE_CNT  = 1 << NODE_W;
    localparam int IN_W      = 24;
    localparam int OUT_W     = 16;
    localparam int CFG_W     = 32;
    localparam int ADDR_W    = 3;

    // node states held in the tree memory
    typedef enum logic [1:0] {
        ND_UNUSED = 2'd0,
        ND_FREE   = 2'd1,
        ND_ALLOC  = 2'd2,
        ND_SPLIT  = 2'd3
    } t_node;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_BADFREE = 2'd2
    } t_status;

    // action codes
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    // commands from controller to datapath
    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLEAR,
        OP_LOAD,
        OP_A_RD,
        OP_A_NEXT,
        OP_A_HIT,
        OP_SP_PAR,
        OP_SP_L,
        OP_SP_R,
        OP_MARK,
        OP_F_RD,
        OP_F_DOWN,
        OP_F_SET,
        OP_M_RD,
        OP_M_WA,
        OP_M_WB,
        OP_M_WP,
        OP_FAIL_SPACE,
        OP_FAIL_FREE,
        OP_OUT
    } t_op;

    // status from datapath to controller
    typedef struct packed {
        logic cfg_wr;
        logic clr_last;
        logic action;
        logic fail_size;
        logic fail_range;
        logic st_free;
        logic st_split;
        logic st_unused;
        logic scan_last;
        logic level_zero;
        logic split_more;
        logic walk_more;
        logic misalign;
        logic at_root;
        logic out_busy;
    } t_dp_stat;

endpackage

// ===== rtl/buddy_block_allocator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buddy_block_allocator_core
// Buddy allocator over 2^pool_order pages with a stream request/result port
// and an APB-style register port for the pool order.
// ----------------------------------------------------------------------------
// One request is handled at a time; its cost is set by the single-port node
// memory, which gives one node access per cycle. An allocate scans the
// levels for a free node and splits it down level by level; a free walks
// down to the block and merges free buddies upward. After reset and after
// every write of pool_order the tree is cleared in a pass over all 2048
// nodes, during which no request is taken. A finished result waits in an
// output register, so the next request may be accepted while it is still
// held.
// ----------------------------------------------------------------------------
module buddy_block_allocator_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // request stream
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    input  logic [bba_pkg::IN_W-1:0]     i_s_tdata,   // req_pages[10:0], free_page[20:11]
    input  logic                         i_s_tuser,   // action[0]
    // result stream
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    output logic [bba_pkg::OUT_W-1:0]    o_m_tdata,   // status[1:0], page_index[11:2]
    // register port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bba_pkg::ADDR_W-1:0]   paddr,
    input  logic [bba_pkg::CFG_W-1:0]    pwdata,
    output logic [bba_pkg::CFG_W-1:0]    prdata,
    output logic                         pready
);
    import bba_pkg::*;

    t_op               op;
    t_dp_stat          stat;
    logic              cfg_wr;
    logic [ORD_W-1:0]  pool_order;
    logic [1:0]        res_status;
    logic [PAGE_W-1:0] res_page;

    // register write decode, pool_order is the only register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign prdata = (paddr[2] == 1'b0) ? CFG_W'(pool_order) : '0;

    bba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (stat),
        .o_op       (op)
    );

    bba_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op         (op),
        .o_stat       (stat),
        .i_cfg_wr     (cfg_wr),
        .i_cfg_order  (pwdata[ORD_W-1:0]),
        .o_pool_order (pool_order),
        .i_action     (i_s_tuser),
        .i_req_pages  (i_s_tdata[REQ_W-1:0]),
        .i_free_page  (i_s_tdata[REQ_W+PAGE_W-1:REQ_W]),
        .o_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .o_status     (res_status),
        .o_page_index (res_page)
    );

    // result packing
    assign o_m_tdata = {{(OUT_W - PAGE_W - 2){1'b0}}, res_page, res_status};

endmodule

// ===== rtl/bba_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_ram
// Generic single-port RAM, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module bba_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/bba_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_ctrl
// Sequencer for the allocator: clearing pass, level scan, split, descent
// and buddy merge, issuing at most one datapath command per cycle.
// ----------------------------------------------------------------------------
module bba_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  bba_pkg::t_dp_stat i_stat,
    output bba_pkg::t_op      o_op
);
    import bba_pkg::*;

    typedef enum logic [14:0] {
        S_CLEAR = 15'h0001,
        S_IDLE  = 15'h0002,
        S_DISP  = 15'h0004,
        S_A_RD  = 15'h0008,
        S_A_CHK = 15'h0010,
        S_SPLIT = 15'h0020,
        S_SP_L  = 15'h0040,
        S_SP_R  = 15'h0080,
        S_F_RD  = 15'h0100,
        S_F_CHK = 15'h0200,
        S_MERGE = 15'h0400,
        S_M_CHK = 15'h0800,
        S_M_WB  = 15'h1000,
        S_M_WP  = 15'h2000,
        S_DONE  = 15'h4000
    } t_state;

    t_state r_state, n_state;
    t_op    op;

    // next state and command
    always_comb begin
        n_state = r_state;
        op      = OP_NONE;
        case (r_state)
            S_CLEAR: begin
                op = OP_CLEAR;
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_s_tvalid) begin
                    op      = OP_LOAD;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                if (i_stat.action == ACT_ALLOC) begin
                    if (i_stat.fail_size) begin
                        op      = OP_FAIL_SPACE;
                        n_state = S_DONE;
                    end else begin
                        op      = OP_A_RD;
                        n_state = S_A_CHK;
                    end
                end else if (i_stat.fail_range) begin
                    op      = OP_FAIL_FREE;
                    n_state = S_DONE;
                end else begin
                    op      = OP_F_RD;
                    n_state = S_F_CHK;
                end
            end
            S_A_RD: begin
                op      = OP_A_RD;
                n_state = S_A_CHK;
            end
            S_A_CHK: begin
                if (i_stat.st_free) begin
                    op      = OP_A_HIT;
                    n_state = S_SPLIT;
                end else if (i_stat.scan_last && i_stat.level_zero) begin
                    op      = OP_FAIL_SPACE;
                    n_state = S_DONE;
                end else begin
                    op      = OP_A_NEXT;
                    n_state = S_A_RD;
                end
            end
            S_SPLIT: begin
                if (i_stat.split_more) begin
                    op      = OP_SP_PAR;
                    n_state = S_SP_L;
                end else begin
                    op      = OP_MARK;
                    n_state = S_DONE;
                end
            end
            S_SP_L: begin
                op      = OP_SP_L;
                n_state = S_SP_R;
            end
            S_SP_R: begin
                op      = OP_SP_R;
                n_state = S_SPLIT;
            end
            S_F_RD: begin
                op      = OP_F_RD;
                n_state = S_F_CHK;
            end
            S_F_CHK: begin
                if (i_stat.walk_more) begin
                    op      = OP_F_DOWN;
                    n_state = S_F_RD;
                end else if (i_stat.st_unused || i_stat.st_split || i_stat.misalign) begin
                    op      = OP_FAIL_FREE;
                    n_state = S_DONE;
                end else begin
                    op      = OP_F_SET;
                    n_state = S_MERGE;
                end
            end
            S_MERGE: begin
                if (i_stat.at_root) begin
                    n_state = S_DONE;
                end else begin
                    op      = OP_M_RD;
                    n_state = S_M_CHK;
                end
            end
            S_M_CHK: begin
                if (i_stat.st_free) begin
                    op      = OP_M_WA;
                    n_state = S_M_WB;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_M_WB: begin
                op      = OP_M_WB;
                n_state = S_M_WP;
            end
            S_M_WP: begin
                op      = OP_M_WP;
                n_state = S_MERGE;
            end
            S_DONE: begin
                if (!i_stat.out_busy) begin
                    op      = OP_OUT;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
        // a pool order write restarts the clearing pass
        if (i_stat.cfg_wr) begin
            op      = OP_NONE;
            n_state = S_CLEAR;
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_op       = op;
    assign o_s_tready = (r_state == S_IDLE) && !i_stat.cfg_wr;

    // an input transfer always starts the dispatch step
    a_load_disp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> (r_state == S_DISP))
        else $error("input transfer did not reach dispatch");

    // a result is only produced when leaving done
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_op == OP_OUT) |-> (r_state == S_DONE))
        else $error("output load outside done state");

    // the clearing pass takes no items
    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_s_tready)
        else $error("ready during clearing pass");

endmodule

// ===== rtl/bba_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_dp
// Datapath: pool order register, request registers, tree walk counters,
// node memory and the result output register.
// ----------------------------------------------------------------------------
module bba_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  bba_pkg::t_op                 i_op,
    output bba_pkg::t_dp_stat            o_stat,
    input  logic                         i_cfg_wr,
    input  logic [bba_pkg::ORD_W-1:0]    i_cfg_order,
    output logic [bba_pkg::ORD_W-1:0]    o_pool_order,
    input  logic                         i_action,
    input  logic [bba_pkg::REQ_W-1:0]    i_req_pages,
    input  logic [bba_pkg::PAGE_W-1:0]   i_free_page,
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    output logic [1:0]                   o_status,
    output logic [bba_pkg::PAGE_W-1:0]   o_page_index
);
    import bba_pkg::*;

    logic [ORD_W-1:0]  r_pool;
    logic              r_action;
    logic              r_fail_size;
    logic [PAGE_W-1:0] r_fpg;
    logic [ORD_W-1:0]  r_de, r_d;
    logic [PAGE_W-1:0] r_p;
    logic [NODE_W-1:0] r_idx;
    logic [PAGE_W-1:0] r_page;
    t_status           r_status;
    logic [NODE_W-1:0] r_clr;
    logic              r_out_valid;
    t_status           r_out_status;
    logic [PAGE_W-1:0] r_out_page;

    logic [REQ_W-1:0]  req_m1;
    logic [ORD_W-1:0]  k_in;
    logic [NODE_W-1:0] scan_addr;
    logic [NODE_W-1:0] level_max;
    logic [ORD_W-1:0]  sh_page;
    logic [ORD_W-1:0]  sh_bit;
    logic [NODE_W-1:0] low_mask;
    logic              walk_bit;
    logic              mem_we;
    logic [NODE_W-1:0] mem_addr;
    t_node             mem_wdata;
    logic [1:0]        mem_rdata;
    t_node             rd_node;

    // round the request up to a power of two
    always_comb begin
        req_m1 = (i_req_pages == '0) ? '0 : i_req_pages - REQ_W'(1);
        k_in   = '0;
        for (int i = 0; i < REQ_W; i++) begin
            if (req_m1[i]) k_in = ORD_W'(i + 1);
        end
    end

    // tree addressing
    assign scan_addr = (NODE_W'(1) << r_d) | NODE_W'(r_p);
    assign level_max = (NODE_W'(1) << r_d) - NODE_W'(1);
    assign sh_page   = r_pool - r_d;
    assign sh_bit    = r_pool - r_d - ORD_W'(1);
    assign low_mask  = (NODE_W'(1) << sh_page) - NODE_W'(1);
    assign walk_bit  = r_fpg[sh_bit];
    assign rd_node   = t_node'(mem_rdata);

    // memory access per command
    always_comb begin
        mem_we    = 1'b0;
        mem_addr  = r_idx;
        mem_wdata = ND_UNUSED;
        case (i_op)
            OP_CLEAR: begin
                mem_we    = 1'b1;
                mem_addr  = r_clr;
                mem_wdata = (r_clr == NODE_W'(1)) ? ND_FREE : ND_UNUSED;
            end
            OP_A_RD:   mem_addr = scan_addr;
            OP_SP_PAR: begin
                mem_we    = 1'b1;
                mem_wdata = ND_SPLIT;
            end
            OP_SP_L: begin
                mem_we    = 1'b1;
                mem_addr  = {r_idx[NODE_W-2:0], 1'b0};
                mem_wdata = ND_FREE;
            end
            OP_SP_R: begin
                mem_we    = 1'b1;
                mem_addr  = {r_idx[NODE_W-2:0], 1'b1};
                mem_wdata = ND_FREE;
            end
            OP_MARK: begin
                mem_we    = 1'b1;
                mem_wdata = ND_ALLOC;
            end
            OP_F_SET: begin
                mem_we    = 1'b1;
                mem_wdata = ND_FREE;
            end
            OP_M_RD:   mem_addr = r_idx ^ NODE_W'(1);
            OP_M_WA:   mem_we   = 1'b1;
            OP_M_WB: begin
                mem_we   = 1'b1;
                mem_addr = r_idx ^ NODE_W'(1);
            end
            OP_M_WP: begin
                mem_we    = 1'b1;
                mem_addr  = r_idx >> 1;
                mem_wdata = ND_FREE;
            end
            default: mem_we = 1'b0;
        endcase
    end

    bba_ram #(
        .WIDTH (2),
        .DEPTH (NODE_CNT)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool      <= ORD_W'(MAX_ORDER);
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr) begin
                r_pool <= (i_cfg_order > ORD_W'(MAX_ORDER)) ? ORD_W'(MAX_ORDER) : i_cfg_order;
                r_clr  <= '0;
            end else if (i_op == OP_CLEAR) begin
                r_clr <= r_clr + NODE_W'(1);
            end
            if (i_op == OP_OUT) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // walk and result registers
    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_LOAD: begin
                r_action    <= i_action;
                r_fpg       <= i_free_page;
                r_fail_size <= k_in > r_pool;
                r_de        <= r_pool - k_in;
                r_d         <= (i_action == ACT_FREE) ? '0 : r_pool - k_in;
                r_p         <= '0;
                r_idx       <= NODE_W'(1);
                r_page      <= '0;
                r_status    <= ST_OK;
            end
            OP_A_NEXT: begin
                if (NODE_W'(r_p) == level_max) begin
                    r_d <= r_d - ORD_W'(1);
                    r_p <= '0;
                end else begin
                    r_p <= r_p + PAGE_W'(1);
                end
            end
            OP_A_HIT: begin
                r_idx  <= scan_addr;
                r_page <= r_p << sh_page;
            end
            OP_SP_R: begin
                r_idx <= {r_idx[NODE_W-2:0], 1'b0};
                r_d   <= r_d + ORD_W'(1);
            end
            OP_MARK: r_status <= ST_OK;
            OP_F_DOWN: begin
                r_idx <= {r_idx[NODE_W-2:0], walk_bit};
                r_d   <= r_d + ORD_W'(1);
            end
            OP_M_WP: r_idx <= r_idx >> 1;
            OP_FAIL_SPACE: begin
                r_status <= ST_NOSPACE;
                r_page   <= '0;
            end
            OP_FAIL_FREE: begin
                r_status <= ST_BADFREE;
                r_page   <= '0;
            end
            OP_OUT: begin
                r_out_status <= r_status;
                r_out_page   <= r_page;
            end
            default: r_idx <= r_idx;
        endcase
    end

    // status towards the controller
    always_comb begin
        o_stat.cfg_wr     = i_cfg_wr;
        o_stat.clr_last   = (r_clr == NODE_W'(NODE_CNT - 1));
        o_stat.action     = r_action;
        o_stat.fail_size  = r_fail_size;
        o_stat.fail_range = (r_fpg >> r_pool) != '0;
        o_stat.st_free    = (rd_node == ND_FREE);
        o_stat.st_split   = (rd_node == ND_SPLIT);
        o_stat.st_unused  = (rd_node == ND_UNUSED);
        o_stat.scan_last  = (NODE_W'(r_p) == level_max);
        o_stat.level_zero = (r_d == '0);
        o_stat.split_more = (r_d < r_de);
        o_stat.walk_more  = (rd_node == ND_SPLIT) && (r_d < r_pool);
        o_stat.misalign   = (NODE_W'(r_fpg) & low_mask) != '0;
        o_stat.at_root    = (r_idx == NODE_W'(1));
        o_stat.out_busy   = r_out_valid && !i_m_tready;
    end

    assign o_pool_order = r_pool;
    assign o_m_tvalid   = r_out_valid;
    assign o_status     = r_out_status;
    assign o_page_index = r_out_page;

    // a failed request never reports a page
    a_fail_page: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == OP_OUT && r_status != ST_OK) |-> (r_page == '0))
        else $error("page reported on failed request");

    // node zero is touched only by the clearing pass
    a_no_node0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && i_op != OP_CLEAR) |-> (mem_addr != '0))
        else $error("write to node zero outside clearing");

    // the pool order never exceeds the tree depth
    a_pool_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_wr |=> (r_pool <= ORD_W'(MAX_ORDER)))
        else $error("pool order above maximum");

endmodule

// ===== sim/buddy_block_allocator_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buddy_block_allocator_core_test
// Self-checking bench for the buddy allocator core. Requests stream in from a
// queue and each result is checked against an in-bench model of the node tree.
// The run covers several pool orders, with random idling on both stream sides.
// ----------------------------------------------------------------------------
module buddy_block_allocator_core_test;
    import bba_pkg::*;

    typedef struct {
        logic        action;
        logic [10:0] req;
        logic [9:0]  fpage;
    } t_req;

    typedef struct {
        t_status    st;
        logic [9:0] pg;
    } t_res;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_s_tvalid;
    logic                o_s_tready;
    logic [IN_W-1:0]     i_s_tdata;   // req_pages[10:0], free_page[20:11]
    logic                i_s_tuser;   // action[0]
    logic                o_m_tvalid;
    logic                i_m_tready;
    logic [OUT_W-1:0]    o_m_tdata;   // status[1:0], page_index[11:2]
    logic                psel, penable, pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [CFG_W-1:0]    pwdata;
    logic [CFG_W-1:0]    prdata;
    logic                pready;

    buddy_block_allocator_core u_top (.*);

    always #5 i_clk = ~i_clk;

    // model state
    t_node   tree [0:NODE_CNT-1];
    int      pool_ord;
    int      live_pages [$];
    t_req    req_q [$];
    t_res    result_q [$];
    t_req    cur;
    int      idle_pct, stall_pct;
    int      mismatches, n_sent, n_checked;

    // tree reset on every pool order write
    function automatic void tree_clear();
        foreach (tree[i]) tree[i] = ND_UNUSED;
        tree[1] = ND_FREE;
        live_pages.delete();
    endfunction

    function automatic void alloc_block(int req, output t_res r);
        int k, de, d, n, p, idx;
        bit hit;
        k = 0;
        hit = 0;
        r.st = ST_NOSPACE;
        r.pg = '0;
        if (req == 0) req = 1;
        while (k < 12 && (1 << k) < req) k++;
        if (k > pool_ord) return;
        de = pool_ord - k;
        d = de;
        forever begin
            n = 1 << d;
            for (p = 0; p < n; p++) begin
                if (tree[n + p] == ND_FREE) begin
                    hit = 1;
                    break;
                end
            end
            if (hit || d == 0) break;
            d--;
        end
        if (!hit) return;
        r.pg = 10'(p << (pool_ord - d));
        idx = (1 << d) + p;
        // split down the left side
        while (d < de) begin
            tree[idx] = ND_SPLIT;
            tree[2*idx] = ND_FREE;
            tree[2*idx+1] = ND_FREE;
            idx = 2 * idx;
            d++;
        end
        tree[idx] = ND_ALLOC;
        r.st = ST_OK;
        live_pages.push_back(int'(r.pg));
    endfunction

    function automatic void free_block(int pg, output t_res r);
        int idx, d, par;
        idx = 1;
        d = 0;
        r.st = ST_BADFREE;
        r.pg = '0;
        if (pg >= (1 << pool_ord)) return;
        while (tree[idx] == ND_SPLIT && d < pool_ord) begin
            idx = 2 * idx + ((pg >> (pool_ord - d - 1)) & 1);
            d++;
        end
        if (tree[idx] == ND_UNUSED || tree[idx] == ND_SPLIT ||
            (pg & ((1 << (pool_ord - d)) - 1)) != 0) return;
        tree[idx] = ND_FREE;
        // merge free buddies upward
        while (idx > 1) begin
            par = idx >> 1;
            if (tree[2*par] == ND_FREE && tree[2*par+1] == ND_FREE) begin
                tree[2*par] = ND_UNUSED;
                tree[2*par+1] = ND_UNUSED;
                tree[par] = ND_FREE;
                idx = par;
            end else begin
                break;
            end
        end
        r.st = ST_OK;
        foreach (live_pages[i]) begin
            if (live_pages[i] == pg) begin
                live_pages.delete(i);
                break;
            end
        end
    endfunction

    // request driver
    always @(posedge i_clk) begin
        t_res r;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                if (cur.action == ACT_ALLOC) alloc_block(cur.req, r);
                else free_block(cur.fpage, r);
                result_q.push_back(r);
                n_sent++;
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (req_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    cur = req_q.pop_front();
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= {3'b0, cur.fpage, cur.req};
                    i_s_tuser  <= cur.action;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_res e;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                n_checked++;
                if (result_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result transfer: %h", o_m_tdata);
                end else begin
                    e = result_q.pop_front();
                    if (o_m_tdata[1:0] !== e.st || o_m_tdata[11:2] !== e.pg) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: status exp %0d got %0d, page exp %0d got %0d",
                                     e.st, o_m_tdata[1:0], e.pg, o_m_tdata[11:2]);
                    end
                end
            end
            i_m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic push_req(logic act, int req, int fp);
        t_req t;
        t.action = act;
        t.req = 11'(req);
        t.fpage = 10'(fp);
        req_q.push_back(t);
    endtask

    task automatic wait_idle();
        while (req_q.size() > 0 || i_s_tvalid || result_q.size() > 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic reg_write(int addr, int val);
        @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= ADDR_W'(addr);
        pwdata <= CFG_W'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == 0) begin
            pool_ord = (val & 15) > MAX_ORDER ? MAX_ORDER : (val & 15);
            tree_clear();
        end
    endtask

    int orders [8] = '{3, 10, 5, 0, 4, 15, 2, 6};

    initial begin
        int sel, hi;
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_s_tuser = 1'b0;
        i_m_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        idle_pct = 0;
        stall_pct = 0;
        mismatches = 0;
        n_sent = 0;
        n_checked = 0;
        pool_ord = MAX_ORDER;
        tree_clear();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: full pool at reset order
        push_req(ACT_ALLOC, 0, 0);
        push_req(ACT_ALLOC, 1, 0);
        push_req(ACT_ALLOC, 1024, 0);
        push_req(ACT_FREE, 0, 1023);
        push_req(ACT_FREE, 0, 0);
        push_req(ACT_FREE, 0, 0);
        push_req(ACT_ALLOC, 3, 0);
        push_req(ACT_ALLOC, 512, 0);
        push_req(ACT_FREE, 0, 512);
        push_req(ACT_FREE, 0, 1);
        push_req(ACT_FREE, 0, 2);
        push_req(ACT_FREE, 0, 0);
        push_req(ACT_ALLOC, 1024, 0);
        wait_idle();
        // single page pool, out of range frees
        reg_write(0, 0);
        push_req(ACT_ALLOC, 2, 0);
        push_req(ACT_ALLOC, 1, 0);
        push_req(ACT_ALLOC, 0, 0);
        push_req(ACT_FREE, 0, 1);
        push_req(ACT_FREE, 0, 1023);
        push_req(ACT_FREE, 0, 0);
        wait_idle();
        // oversize order saturates; unmapped register is ignored
        reg_write(0, 15);
        reg_write(4, 2);
        push_req(ACT_ALLOC, 1024, 0);
        push_req(ACT_ALLOC, 1, 0);
        push_req(ACT_FREE, 0, 0);
        wait_idle();

        // random phases, mostly well-formed alloc/free traffic
        foreach (orders[ph]) begin
            reg_write(0, orders[ph]);
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 75; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 75; end
                default: begin idle_pct = 33; stall_pct = 33; end
            endcase
            for (int n = 0; n < 88; n++) begin
                while (req_q.size() >= 2) @(posedge i_clk);
                sel = $urandom_range(99);
                hi = 1 << pool_ord;
                if (sel < 45) begin
                    if ($urandom_range(9) == 0)
                        push_req(ACT_ALLOC, $urandom_range(1024), $urandom_range(1023));
                    else
                        push_req(ACT_ALLOC, $urandom_range(hi < 4 ? hi : hi / 4),
                                 $urandom_range(1023));
                end else if (sel < 88 && live_pages.size() > 0) begin
                    push_req(ACT_FREE, $urandom_range(2047),
                             live_pages[$urandom_range(live_pages.size() - 1)]);
                end else begin
                    push_req(ACT_FREE, $urandom_range(2047),
                             $urandom_range(1) ? $urandom_range(1023)
                                               : $urandom_range(hi - 1));
                end
            end
            wait_idle();
        end

        repeat (100) @(posedge i_clk);
        $display("covered %0d requests over pool orders 0 to 10, %0d results checked",
                 n_sent, n_checked);
        if (mismatches == 0 && result_q.size() == 0) begin
            $display("buddy_block_allocator_core verification clean");
        end else begin
            $display("%0d mismatches, %0d results outstanding", mismatches, result_q.size());
            $display("buddy_block_allocator_core verification failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #100ms;
        $display("timeout");
        $display("buddy_block_allocator_core verification failed");
        $finish;
    end

endmodule
